/* design/cph_pkg.sv */
// Shared constants, types and angle table for the complex phase unit.
`timescale 1ns / 1ps
`default_nettype none

package cph_pkg;

    localparam int Z_W         = 20;
    localparam int ATAN_LEN    = 24;
    localparam int TH_W        = 19;
    localparam int PH_W        = 16;
    localparam int NUM_W       = 28;
    localparam int PROD_W      = 49;
    localparam int RECIP_SHIFT = 40;
    localparam int Q_W         = 9;
    localparam int REM_W       = 21;
    localparam int SCALE_SHIFT = 16;

    typedef logic [15:0]         t_atan;
    typedef logic signed [Z_W-1:0] t_angle;
    typedef logic [TH_W-1:0]     t_theta;
    typedef logic [PH_W-1:0]     t_phase;

    localparam t_angle PI_Q16      = 20'sd205887;
    localparam t_angle HALF_PI_Q16 = 20'sd102944;
    localparam t_angle TWO_PI_Q16  = 20'sd411774;

    localparam t_phase RAD_Q13_MAX    = 16'd51472;
    localparam t_phase PHASE_BYTE_MAX = 16'd255;

    localparam logic [9:0]  BYTE_MUL = 10'd510;
    localparam logic [19:0] BYTE_DEN = 20'd823548;
    localparam logic [20:0] BYTE_RECIP =
        21'((64'd1 << RECIP_SHIFT) / 64'd823548);

    localparam t_atan ATAN_Q16 [ATAN_LEN] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047,
        16'd1024,  16'd512,   16'd256,   16'd128,  16'd64,   16'd32,
        16'd16,    16'd8,     16'd4,     16'd2,    16'd1,    16'd0,
        16'd0,     16'd0,     16'd0,     16'd0,    16'd0,    16'd0
    };

endpackage

`default_nettype wire

/* design/cph_in_if.sv */
// Input channel: one complex pixel per beat.
`timescale 1ns / 1ps
`default_nettype none

interface cph_in_if #(
    parameter int W = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] real_part;
    logic signed [W-1:0] imag_part;

    modport source (output valid, output real_part, output imag_part, input ready);
    modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

`default_nettype wire

/* design/cph_out_if.sv */
// Output channel: one phase value per beat.
`timescale 1ns / 1ps
`default_nettype none

interface cph_out_if ();
    logic                 valid;
    logic                 ready;
    cph_pkg::t_phase      phase_value;

    modport source (output valid, output phase_value, input ready);
    modport sink   (input valid, input phase_value, output ready);
endinterface

`default_nettype wire

/* design/cph_cordic_stage.sv */
// One registered CORDIC vectoring iteration with a fixed shift.
`timescale 1ns / 1ps
`default_nettype none

module cph_cordic_stage #(
    parameter int XW    = 34,
    parameter int SHIFT = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic signed [XW-1:0]   i_x,
    input  wire logic signed [XW-1:0]   i_y,
    input  wire cph_pkg::t_angle        i_z,
    input  wire logic                   i_zero,
    output logic signed [XW-1:0]        o_x,
    output logic signed [XW-1:0]        o_y,
    output cph_pkg::t_angle             o_z,
    output logic                        o_zero
);

    localparam cph_pkg::t_angle ANG =
        $signed(cph_pkg::Z_W'(cph_pkg::ATAN_Q16[SHIFT]));

    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    cph_pkg::t_angle      n_z;

    always_comb begin
        if (!i_y[XW-1]) begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + ANG;
        end else begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_zero <= i_zero;
        end
    end

endmodule

`default_nettype wire

/* design/complex_phase_unit.sv */
// Top level: phase plus pi of a complex pixel, radians Q3.13 or byte scale.
// Throughput: one beat per cycle; each stage holds only while the one after is full.
// Stages: pre-rotation, one CORDIC iteration each, theta clamp, scale, reciprocal
// multiply, remainder, output register.
// Reset (synchronous, active low) clears all valid bits and selects radians mode.
`timescale 1ns / 1ps
`default_nettype none

module complex_phase_unit #(
    parameter int INPUT_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_wdata,
    cph_in_if.sink      i_pix,
    cph_out_if.source   o_phase
);

    localparam int NC = (CORDIC_STAGES < cph_pkg::ATAN_LEN) ?
                        CORDIC_STAGES : cph_pkg::ATAN_LEN;
    localparam int XW = INPUT_WIDTH + 18;
    localparam int NS = NC + 6;
    localparam int ST_TH   = NC + 1;
    localparam int ST_NUM  = NC + 2;
    localparam int ST_PROD = NC + 3;
    localparam int ST_REM  = NC + 4;
    localparam int ST_OUT  = NC + 5;

    logic          r_mode;
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // stage k may load when it is empty or stage k+1 loads too
    genvar k;
    generate
        for (k = 0; k < NS - 1; k++) begin : g_en
            assign w_en[k] = !r_vld[k] || w_en[k+1];
        end
    endgenerate
    assign w_en[NS-1] = !r_vld[NS-1] || o_phase.ready;

    assign n_vld = {r_vld[NS-2:0], i_pix.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= n_vld[s];
                end
            end
        end
    end

    assign i_pix.ready   = w_en[0];
    assign o_phase.valid = r_vld[ST_OUT];

    // pre-rotation into the right half plane
    logic signed [XW-1:0] w_sx;
    logic signed [XW-1:0] w_sy;
    logic signed [XW-1:0] n_x0;
    logic signed [XW-1:0] n_y0;
    cph_pkg::t_angle      n_z0;
    logic signed [XW-1:0] r_x0;
    logic signed [XW-1:0] r_y0;
    cph_pkg::t_angle      r_z0;
    logic                 r_zero0;

    assign w_sx = XW'(i_pix.real_part);
    assign w_sy = XW'(i_pix.imag_part);

    always_comb begin
        if (!w_sx[XW-1]) begin
            n_x0 = w_sx;
            n_y0 = w_sy;
            n_z0 = '0;
        end else if (!w_sy[XW-1]) begin
            n_x0 = w_sy;
            n_y0 = -w_sx;
            n_z0 = cph_pkg::HALF_PI_Q16;
        end else begin
            n_x0 = -w_sy;
            n_y0 = w_sx;
            n_z0 = -cph_pkg::HALF_PI_Q16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_x0    <= n_x0 <<< cph_pkg::SCALE_SHIFT;
            r_y0    <= n_y0 <<< cph_pkg::SCALE_SHIFT;
            r_z0    <= n_z0;
            r_zero0 <= (w_sx == '0) && (w_sy == '0);
        end
    end

    logic signed [XW-1:0] stg_x [0:NC];
    logic signed [XW-1:0] stg_y [0:NC];
    cph_pkg::t_angle      stg_z [0:NC];
    logic                 stg_zero [0:NC];

    assign stg_x[0]    = r_x0;
    assign stg_y[0]    = r_y0;
    assign stg_z[0]    = r_z0;
    assign stg_zero[0] = r_zero0;

    generate
        for (k = 0; k < NC; k++) begin : g_cordic
            cph_cordic_stage #(
                .XW    (XW),
                .SHIFT (k)
            ) u_stage (
                .i_clk  (i_clk),
                .i_en   (w_en[k+1]),
                .i_x    (stg_x[k]),
                .i_y    (stg_y[k]),
                .i_z    (stg_z[k]),
                .i_zero (stg_zero[k]),
                .o_x    (stg_x[k+1]),
                .o_y    (stg_y[k+1]),
                .o_z    (stg_z[k+1]),
                .o_zero (stg_zero[k+1])
            );
        end
    endgenerate

    // theta = z + pi, clamped to 0 .. 2*pi; a zero pixel gives pi
    cph_pkg::t_angle  w_zpi;
    cph_pkg::t_theta  n_theta;
    cph_pkg::t_theta  r_theta;

    assign w_zpi = stg_z[NC] + cph_pkg::PI_Q16;

    always_comb begin
        if (stg_zero[NC]) begin
            n_theta = cph_pkg::TH_W'(cph_pkg::PI_Q16);
        end else if (w_zpi[cph_pkg::Z_W-1]) begin
            n_theta = '0;
        end else if (w_zpi > cph_pkg::TWO_PI_Q16) begin
            n_theta = cph_pkg::TH_W'(cph_pkg::TWO_PI_Q16);
        end else begin
            n_theta = cph_pkg::TH_W'(w_zpi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_TH]) begin
            r_theta <= n_theta;
        end
    end

    // byte numerator and rounded radians
    logic [cph_pkg::TH_W:0]        w_rsum;
    logic [cph_pkg::TH_W-3:0]      w_rad;
    logic [cph_pkg::NUM_W-1:0]     r_num;
    cph_pkg::t_phase               r_rad;

    assign w_rsum = (cph_pkg::TH_W + 1)'(r_theta) + (cph_pkg::TH_W + 1)'(4);
    assign w_rad  = w_rsum[cph_pkg::TH_W:3];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_NUM]) begin
            r_num <= cph_pkg::NUM_W'(r_theta) * cph_pkg::NUM_W'(cph_pkg::BYTE_MUL)
                   + cph_pkg::NUM_W'(cph_pkg::TWO_PI_Q16);
            if (w_rad > (cph_pkg::TH_W - 2)'(cph_pkg::RAD_Q13_MAX)) begin
                r_rad <= cph_pkg::RAD_Q13_MAX;
            end else begin
                r_rad <= cph_pkg::PH_W'(w_rad);
            end
        end
    end

    // quotient estimate by reciprocal, low by at most one
    logic [cph_pkg::PROD_W-1:0] r_prod;
    logic [cph_pkg::NUM_W-1:0]  r_num2;
    cph_pkg::t_phase            r_rad2;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_PROD]) begin
            r_prod <= cph_pkg::PROD_W'(r_num) * cph_pkg::PROD_W'(cph_pkg::BYTE_RECIP);
            r_num2 <= r_num;
            r_rad2 <= r_rad;
        end
    end

    logic [cph_pkg::Q_W-1:0]    w_q0;
    logic [cph_pkg::NUM_W:0]    w_qd;
    logic [cph_pkg::NUM_W:0]    w_diff;
    logic [cph_pkg::Q_W-1:0]    r_q0;
    logic [cph_pkg::REM_W-1:0]  r_rem;
    cph_pkg::t_phase            r_rad3;

    assign w_q0   = r_prod[cph_pkg::PROD_W-1:cph_pkg::RECIP_SHIFT];
    assign w_qd   = (cph_pkg::NUM_W + 1)'(w_q0) * (cph_pkg::NUM_W + 1)'(cph_pkg::BYTE_DEN);
    assign w_diff = (cph_pkg::NUM_W + 1)'(r_num2) - w_qd;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_REM]) begin
            r_q0   <= w_q0;
            r_rem  <= w_diff[cph_pkg::REM_W-1:0];
            r_rad3 <= r_rad2;
        end
    end

    logic [cph_pkg::Q_W:0] w_q;
    cph_pkg::t_phase       w_byte;
    cph_pkg::t_phase       r_out;

    assign w_q = (cph_pkg::Q_W + 1)'(r_q0)
               + (cph_pkg::Q_W + 1)'(r_rem >= cph_pkg::REM_W'(cph_pkg::BYTE_DEN));
    assign w_byte = (w_q > (cph_pkg::Q_W + 1)'(cph_pkg::PHASE_BYTE_MAX)) ?
                    cph_pkg::PHASE_BYTE_MAX : cph_pkg::PH_W'(w_q);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_out <= r_mode ? w_byte : r_rad3;
        end
    end

    assign o_phase.phase_value = r_out;

`ifndef NO_ASSERTIONS
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> ((&r_vld) && !o_phase.ready))
        else $error("input stalled while pipeline has room");

    a_rad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_phase.valid |-> (o_phase.phase_value <= cph_pkg::RAD_Q13_MAX))
        else $error("phase value out of range");

    a_theta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_TH] |-> (r_theta <= cph_pkg::TH_W'(cph_pkg::TWO_PI_Q16)))
        else $error("theta beyond two pi");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_REM] |->
            (r_rem < (cph_pkg::REM_W'(cph_pkg::BYTE_DEN) << 1)))
        else $error("reciprocal quotient off by more than one");
`endif

endmodule

`default_nettype wire
